@@ hdl/tcgr_pkg.sv @@
// tcgr_pkg: shared types and constants for the text console glyph renderer
// no dependencies
package tcgr_pkg;

  typedef enum logic [1:0] {
    FUNC_TEXT     = 2'd0,
    FUNC_CURSOR   = 2'd1,
    FUNC_LD_CODE  = 2'd2,
    FUNC_LD_ROW   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_FB_WIDTH     = 3'd0,
    REG_FB_HEIGHT    = 3'd1,
    REG_FONT_WIDTH   = 3'd2,
    REG_FONT_HEIGHT  = 3'd3,
    REG_SCALE        = 3'd4,
    REG_GLYPH_COUNT  = 3'd5,
    REG_PIXEL_FORMAT = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FALLBACK,
    ST_FETCH,
    ST_WAIT,
    ST_ROW,
    ST_EMIT,
    ST_ADVANCE
  } state_t;

  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [15:0] cursor_x_in;
    logic [15:0] cursor_y_in;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [6:0]  glyph_index;
    logic [3:0]  row_index;
    logic [15:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_y;
    logic [15:0] pixel_x;
    logic [63:0] pixel_mask;
    logic [23:0] color_word;
    logic [6:0]  scroll_rows;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  // mask builder control
  typedef struct packed {
    logic        start;
    logic [15:0] bits;
    logic [4:0]  fw;
    logic [2:0]  s;
    logic [15:0] col;
    logic [15:0] fb_width;
  } mask_req_t;

endpackage

@@ hdl/tcgr_if.sv @@
// tcgr_if: valid/ready channel interfaces for items and configuration
// depends on tcgr_pkg
interface tcgr_in_if;
  logic valid;
  logic ready;
  tcgr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcgr_out_if;
  logic valid;
  logic ready;
  tcgr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcgr_cfg_if;
  logic valid;
  logic ready;
  tcgr_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/tcgr_ram.sv @@
// tcgr_ram: generic single-port write, single read port RAM with registered read
// no dependencies
module tcgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/tcgr_mask.sv @@
// tcgr_mask: builds one scaled, clipped 64-bit pixel mask
// depends on tcgr_pkg
module tcgr_mask (
  input  logic                 clk,
  input  logic                 rst,
  input  tcgr_pkg::mask_req_t  req,
  output logic                 done,
  output logic [63:0]          mask
);
  logic [5:0]  j;
  logic [4:0]  col;
  logic [2:0]  sub;
  logic        busy;
  logic        lit;
  logic [16:0] xpos;

  // one mask bit per cycle: column col, sub-pixel sub
  assign xpos = {1'b0, req.col} + {11'd0, j};
  assign lit  = (col < req.fw) && req.bits[4'(15 - col[3:0])] && (col[4] == 1'b0)
                && (xpos < {1'b0, req.fb_width});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        j    <= '0;
        col  <= '0;
        sub  <= '0;
        mask <= '0;
      end else if (busy) begin
        mask[j] <= lit;
        j <= j + 6'd1;
        if (sub + 3'd1 == req.s) begin
          sub <= '0;
          col <= (col == 5'd16) ? col : col + 5'd1;
        end else begin
          sub <= sub + 3'd1;
        end
        if (j == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ hdl/text_console_glyph_renderer.sv @@
// text_console_glyph_renderer: top level of the text console character generator
// depends on tcgr_pkg, tcgr_if, tcgr_ram, tcgr_mask
//
// Usage: glyph codes (func 2) and glyph rows (func 3) are loaded through the
// input channel before text is sent; func 1 sets the cursor. A text byte
// (func 0) yields font_height*scale row transactions on the output channel,
// the last one flagged by last and carrying scroll_rows when the text ran
// past the bottom edge. A newline only moves the cursor.
// Configuration must be written on cfg only while no character is in flight;
// the block itself does not enforce this. A lookup walks the code table one
// entry per cycle, walking it again for '?' as a fallback when the code is not
// found; each result row is then built in the shared mask builder, which checks
// one pixel per cycle, after its glyph row has been fetched. Loads, cursor
// commands and newlines are taken back to back while idle.
// One item is handled at a time.
// Reset clears the cursor and restores the default configuration; the glyph
// tables keep their contents and must be loaded before use. When the
// receiver stalls the output item holds and the block waits.
module text_console_glyph_renderer #(
  parameter int GLYPH_ENTRIES   = 128,
  parameter int MAX_FONT_HEIGHT = 16,
  parameter int MAX_FONT_WIDTH  = 16,
  parameter int MAX_SCALE       = 4
) (
  input  logic     clk,
  input  logic     rst,
  tcgr_in_if.sink   in_ch,
  tcgr_out_if.source out_ch,
  tcgr_cfg_if.sink  cfg
);
  localparam int GW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam int RD = GLYPH_ENTRIES * MAX_FONT_HEIGHT;
  localparam int RW = $clog2(RD);
  localparam int CW = $clog2(GLYPH_ENTRIES + 1);

  // configuration registers
  logic [15:0] fb_width, fb_height;
  logic [4:0]  font_width, font_height;
  logic [2:0]  scale;
  logic [7:0]  glyph_count;
  logic        pixel_format;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width <= 16'd640; fb_height <= 16'd480; font_width <= 5'd8;
      font_height <= 5'd16; scale <= 3'd1; glyph_count <= 8'd128; pixel_format <= 1'b0;
    end else if (cfg.valid) begin
      case (tcgr_pkg::reg_idx_t'(cfg.data.index))
        tcgr_pkg::REG_FB_WIDTH:     fb_width <= cfg.data.data;
        tcgr_pkg::REG_FB_HEIGHT:    fb_height <= cfg.data.data;
        tcgr_pkg::REG_FONT_WIDTH:   font_width <= cfg.data.data[4:0];
        tcgr_pkg::REG_FONT_HEIGHT:  font_height <= cfg.data.data[4:0];
        tcgr_pkg::REG_SCALE:        scale <= cfg.data.data[2:0];
        tcgr_pkg::REG_GLYPH_COUNT:  glyph_count <= cfg.data.data[7:0];
        tcgr_pkg::REG_PIXEL_FORMAT: pixel_format <= cfg.data.data[0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [2:0] s_eff;
  logic [4:0] fw_eff, fh_eff;
  logic [CW-1:0] n_eff;
  logic [6:0] line;
  assign s_eff  = (scale == 3'd0) ? 3'd1 :
                  ({29'd0, scale} > MAX_SCALE) ? 3'(MAX_SCALE) : scale;
  assign fw_eff = ({27'd0, font_width} > MAX_FONT_WIDTH) ? 5'(MAX_FONT_WIDTH) : font_width;
  assign fh_eff = ({27'd0, font_height} > MAX_FONT_HEIGHT) ? 5'(MAX_FONT_HEIGHT)
                  : font_height;
  assign n_eff  = ({24'd0, glyph_count} > GLYPH_ENTRIES) ? CW'(GLYPH_ENTRIES)
                  : CW'(glyph_count);

  tcgr_pkg::state_t state, state_next;
  tcgr_pkg::in_item_t item;
  logic [15:0] cursor_col, cursor_row;
  logic [CW-1:0] idx;
  logic [GW-1:0] gsel;
  logic [4:0] r;
  logic [2:0] dy;
  logic [6:0] cnt;
  logic [16:0] y;
  logic [15:0] rowbits;
  logic mask_done;
  logic [63:0] mask;
  tcgr_pkg::mask_req_t mreq;
  logic scan_hit, scan_end;

  // glyph code table and glyph row table
  logic        code_we, row_we;
  logic [7:0]  code_rd;
  logic [15:0] row_rd;
  logic [GW-1:0] code_raddr;
  logic [RW-1:0] row_raddr;
  logic accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign code_we = accept && (tcgr_pkg::func_t'(in_ch.data.func) == tcgr_pkg::FUNC_LD_CODE)
                   && ({25'd0, in_ch.data.glyph_index} < GLYPH_ENTRIES);
  assign row_we  = accept && (tcgr_pkg::func_t'(in_ch.data.func) == tcgr_pkg::FUNC_LD_ROW)
                   && ({25'd0, in_ch.data.glyph_index} < GLYPH_ENTRIES)
                   && ({28'd0, in_ch.data.row_index} < MAX_FONT_HEIGHT);
  assign code_raddr = idx[GW-1:0];
  assign row_raddr  = RW'(gsel) * RW'(MAX_FONT_HEIGHT) + RW'(r);

  tcgr_ram #(.WIDTH(8), .DEPTH(GLYPH_ENTRIES)) u_codes (
    .clk(clk), .we(code_we), .waddr(GW'(in_ch.data.glyph_index)),
    .wdata(in_ch.data.char_code), .raddr(code_raddr), .rdata(code_rd));

  tcgr_ram #(.WIDTH(16), .DEPTH(RD)) u_rows (
    .clk(clk), .we(row_we),
    .waddr(RW'(in_ch.data.glyph_index) * RW'(MAX_FONT_HEIGHT)
           + RW'(in_ch.data.row_index)),
    .wdata(in_ch.data.row_bits), .raddr(row_raddr), .rdata(row_rd));

  // scan compare: code_rd belongs to entry idx-1 (scan_idx) in the cycle after the read
  logic scan_vld;
  logic [CW-1:0] scan_idx;
  logic [7:0] target;
  assign target   = (state == tcgr_pkg::ST_FALLBACK) ? tcgr_pkg::CHAR_QUESTION
                    : item.char_code;
  assign scan_hit = scan_vld && (code_rd == target);
  assign scan_end = (idx >= n_eff) && !scan_vld;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tcgr_pkg::ST_IDLE:
        if (accept && tcgr_pkg::func_t'(in_ch.data.func) == tcgr_pkg::FUNC_TEXT
            && in_ch.data.char_code != tcgr_pkg::CHAR_NEWLINE)
          state_next = tcgr_pkg::ST_SEARCH;
      tcgr_pkg::ST_SEARCH:
        if (scan_hit) state_next = tcgr_pkg::ST_FETCH;
        else if (scan_end) state_next = tcgr_pkg::ST_FALLBACK;
      tcgr_pkg::ST_FALLBACK:
        if (scan_hit || scan_end) state_next = tcgr_pkg::ST_FETCH;
      tcgr_pkg::ST_FETCH:
        state_next = (r >= fh_eff) ? tcgr_pkg::ST_ADVANCE : tcgr_pkg::ST_WAIT;
      tcgr_pkg::ST_WAIT: state_next = tcgr_pkg::ST_ROW;
      tcgr_pkg::ST_ROW:
        if (mask_done) state_next = tcgr_pkg::ST_EMIT;
      tcgr_pkg::ST_EMIT:
        if (out_ch.ready) begin
          if (dy + 3'd1 < s_eff) state_next = tcgr_pkg::ST_WAIT;
          else state_next = tcgr_pkg::ST_FETCH;
        end
      tcgr_pkg::ST_ADVANCE: state_next = tcgr_pkg::ST_IDLE;
      default: state_next = tcgr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready  = (state == tcgr_pkg::ST_IDLE);
    out_ch.valid = (state == tcgr_pkg::ST_EMIT);
    mreq.start    = (state == tcgr_pkg::ST_WAIT);
    mreq.bits     = rowbits;
    mreq.fw       = fw_eff;
    mreq.s        = s_eff;
    mreq.col      = cursor_col;
    mreq.fb_width = fb_width;
  end

  tcgr_mask u_mask (.clk(clk), .rst(rst), .req(mreq), .done(mask_done), .mask(mask));

  // result payload
  logic [6:0] total;
  logic       is_last, do_scroll;
  assign total     = {2'd0, fh_eff} * {4'd0, s_eff};
  assign is_last   = (cnt + 7'd1 == total);
  assign line      = total;
  assign do_scroll = ({1'b0, cursor_row} + {10'd0, line}) > {1'b0, fb_height};
  assign y         = {1'b0, cursor_row} + {10'd0, cnt};
  always_comb begin
    out_ch.data.pixel_y     = y[16] ? 16'hFFFF : y[15:0];
    out_ch.data.pixel_x     = cursor_col;
    out_ch.data.pixel_mask  = (y < {1'b0, fb_height}) ? mask : 64'd0;
    out_ch.data.color_word  = pixel_format ? {item.blue, item.green, item.red}
                                           : {item.red, item.green, item.blue};
    out_ch.data.scroll_rows = (is_last && do_scroll) ? line : 7'd0;
    out_ch.data.last        = is_last;
  end

  // datapath registers
  logic [16:0] col_sum, row_sum;
  assign col_sum = {1'b0, cursor_col} + ({12'd0, fw_eff} * {14'd0, s_eff});
  assign row_sum = {1'b0, cursor_row} + {10'd0, line};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcgr_pkg::ST_IDLE;
      cursor_col <= '0;
      cursor_row <= '0;
      scan_vld <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        tcgr_pkg::ST_IDLE: begin
          idx <= '0; scan_vld <= 1'b0; gsel <= '0; r <= '0; dy <= '0; cnt <= '0;
          if (accept) begin
            item <= in_ch.data;
            case (tcgr_pkg::func_t'(in_ch.data.func))
              tcgr_pkg::FUNC_CURSOR: begin
                cursor_col <= in_ch.data.cursor_x_in;
                cursor_row <= in_ch.data.cursor_y_in;
              end
              tcgr_pkg::FUNC_TEXT:
                if (in_ch.data.char_code == tcgr_pkg::CHAR_NEWLINE) begin
                  cursor_col <= '0;
                  cursor_row <= row_sum[16] ? 16'hFFFF : row_sum[15:0];
                end
              default: ;
            endcase
          end
        end
        tcgr_pkg::ST_SEARCH, tcgr_pkg::ST_FALLBACK: begin
          if (scan_hit) begin
            gsel <= scan_idx[GW-1:0];
            scan_vld <= 1'b0;
          end else if (scan_end) begin
            idx <= '0;
            if (state == tcgr_pkg::ST_FALLBACK) gsel <= '0;
          end else begin
            scan_vld <= (idx < n_eff);
            scan_idx <= idx;
            if (idx < n_eff) idx <= idx + CW'(1);
          end
        end
        tcgr_pkg::ST_FETCH: dy <= '0;
        tcgr_pkg::ST_WAIT: if (dy == 3'd0) rowbits <= row_rd;
        tcgr_pkg::ST_EMIT:
          if (out_ch.ready) begin
            cnt <= cnt + 7'd1;
            if (dy + 3'd1 < s_eff) dy <= dy + 3'd1;
            else r <= r + 5'd1;
          end
        tcgr_pkg::ST_ADVANCE: begin
          cursor_col <= col_sum[16] ? 16'hFFFF : col_sum[15:0];
          if (do_scroll)
            cursor_row <= (cursor_row > {9'd0, line}) ? cursor_row - {9'd0, line} : '0;
        end
        default: ;
      endcase
    end
  end

  // a result is only offered while a character is being drawn
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> cnt < total)
    else $error("row count exceeds glyph height");

  // the input is closed while a row mask is being built
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == tcgr_pkg::ST_ROW) |-> !in_ch.ready)
    else $error("input open during drawing");

  // a stalled result keeps its row
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(cnt))
    else $error("stalled result changed");

endmodule
